FILE: design/mmcrc_pkg.sv
package mmcrc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE = 2'd0,
        CFG_POLY = 2'd1,
        CFG_INIT = 2'd2
    } t_cfg_reg;

    // CRC modes; unused codes fold onto MODE_CRC8 in decode_mode
    typedef enum logic [2:0] {
        MODE_CRC4      = 3'd0,
        MODE_CRC7      = 3'd1,
        MODE_CRC8      = 3'd2,
        MODE_CRC8_REF  = 3'd3,
        MODE_CRC16_MSB = 3'd4,
        MODE_CRC16_LSB = 3'd5
    } t_mode;

    localparam logic [2:0] MODE_RESET = 3'd2;
    localparam logic [15:0] POLY_RESET = 16'h0007;
    localparam logic [15:0] INIT_RESET = 16'h0000;

    // one classified byte, as queued between front and back end
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        t_mode       mode;
        logic [15:0] gen;
        logic [15:0] load;
    } t_item;

    function automatic logic [7:0] flip8(input logic [7:0] x);
        logic [7:0] y;
        for (int i = 0; i < 8; i++) begin
            y[i] = x[7-i];
        end
        return y;
    endfunction

    function automatic t_mode decode_mode(input logic [2:0] code);
        t_mode m;
        unique case (code)
            3'd0:    m = MODE_CRC4;
            3'd1:    m = MODE_CRC7;
            3'd3:    m = MODE_CRC8_REF;
            3'd4:    m = MODE_CRC16_MSB;
            3'd5:    m = MODE_CRC16_LSB;
            default: m = MODE_CRC8;
        endcase
        return m;
    endfunction

endpackage

FILE: design/mmcrc_front.sv
module mmcrc_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [mmcrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mmcrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_cfg_ready,
    input  logic                            i_push,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_first_byte,
    input  logic                            i_last_byte,
    output logic                            o_full,
    output mmcrc_pkg::t_item                o_item,
    output logic                            o_item_valid,
    input  logic                            i_item_take
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [2:0]  r_mode;
    logic [15:0] r_poly;
    logic [15:0] r_init;

    mmcrc_pkg::t_mode w_mode;
    logic [15:0]      w_gen;
    logic [15:0]      w_load;
    mmcrc_pkg::t_item w_item;

    mmcrc_pkg::t_item r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mmcrc_pkg::MODE_RESET;
            r_poly <= mmcrc_pkg::POLY_RESET;
            r_init <= mmcrc_pkg::INIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (mmcrc_pkg::t_cfg_reg'(i_cfg_index))
                mmcrc_pkg::CFG_MODE: r_mode <= i_cfg_data[2:0];
                mmcrc_pkg::CFG_POLY: r_poly <= i_cfg_data;
                mmcrc_pkg::CFG_INIT: r_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // narrow modes run left-aligned in an 8-bit window
    always_comb begin
        w_mode = mmcrc_pkg::decode_mode(r_mode);
        unique case (w_mode) inside
            mmcrc_pkg::MODE_CRC4: begin
                w_gen  = {8'h00, r_poly[3:0], 4'h0};
                w_load = {8'h00, r_init[3:0], 4'h0};
            end
            mmcrc_pkg::MODE_CRC7: begin
                w_gen  = {8'h00, r_poly[6:0], 1'b0};
                w_load = {8'h00, r_init[6:0], 1'b0};
            end
            mmcrc_pkg::MODE_CRC8_REF: begin
                w_gen  = {8'h00, mmcrc_pkg::flip8(r_poly[7:0])};
                w_load = {8'h00, mmcrc_pkg::flip8(r_init[7:0])};
            end
            mmcrc_pkg::MODE_CRC16_MSB, mmcrc_pkg::MODE_CRC16_LSB: begin
                w_gen  = r_poly;
                w_load = r_init;
            end
            default: begin
                w_gen  = {8'h00, r_poly[7:0]};
                w_load = {8'h00, r_init[7:0]};
            end
        endcase
    end

    always_comb begin
        w_item.data  = i_data_byte;
        w_item.first = i_first_byte;
        w_item.last  = i_last_byte;
        w_item.mode  = w_mode;
        w_item.gen   = w_gen;
        w_item.load  = w_load;
    end

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_q[r_rd_ptr];
    assign w_wr         = i_push && !o_full;
    assign w_rd         = i_item_take && o_item_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

FILE: design/mmcrc_back.sv
module mmcrc_back #(
    parameter int RESULT_DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mmcrc_pkg::t_item i_item,
    input  logic             i_item_valid,
    output logic             o_item_take,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [15:0]      o_check_value
);

    localparam int PTR_W = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
    localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

    // eight unrolled bit steps of the selected shift direction
    function automatic logic [15:0] crc_step(input mmcrc_pkg::t_mode mode,
                                             input logic [15:0] base,
                                             input logic [7:0]  d,
                                             input logic [15:0] g);
        logic [15:0] r;
        case (mode) inside
            mmcrc_pkg::MODE_CRC8_REF, mmcrc_pkg::MODE_CRC16_LSB: begin
                r = (mode == mmcrc_pkg::MODE_CRC8_REF) ? {8'h00, base[7:0] ^ d}
                                                       : base ^ {8'h00, d};
                for (int b = 0; b < 8; b++) begin
                    r = r[0] ? ((r >> 1) ^ g) : (r >> 1);
                end
            end
            mmcrc_pkg::MODE_CRC16_MSB: begin
                r = base ^ {d, 8'h00};
                for (int b = 0; b < 8; b++) begin
                    r = r[15] ? ((r << 1) ^ g) : (r << 1);
                end
            end
            default: begin
                r = {8'h00, base[7:0] ^ d};
                for (int b = 0; b < 8; b++) begin
                    r = {8'h00, r[6:0], 1'b0} ^ (r[7] ? {8'h00, g[7:0]} : 16'h0000);
                end
            end
        endcase
        return r;
    endfunction

    logic [15:0]      r_crc;
    logic [15:0]      w_base;
    logic [15:0]      w_next;
    logic [15:0]      w_result;

    logic [15:0]      r_res [RESULT_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign o_item_take = i_item_valid && (r_count != CNT_W'(RESULT_DEPTH));
    assign w_base      = i_item.first ? i_item.load : r_crc;
    assign w_next      = crc_step(i_item.mode, w_base, i_item.data, i_item.gen);

    always_comb begin
        case (i_item.mode) inside
            mmcrc_pkg::MODE_CRC4:      w_result = {12'h000, w_next[7:4]};
            mmcrc_pkg::MODE_CRC7:      w_result = {9'h000, w_next[7:1]};
            mmcrc_pkg::MODE_CRC16_MSB,
            mmcrc_pkg::MODE_CRC16_LSB: w_result = w_next;
            default:                   w_result = {8'h00, w_next[7:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
        end else if (o_item_take) begin
            r_crc <= w_next;
        end
    end

    assign w_wr          = o_item_take && i_item.last;
    assign w_rd          = i_pop && !o_empty;
    assign o_empty       = (r_count == '0);
    assign o_check_value = r_res[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(RESULT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(RESULT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_res[r_wr_ptr] <= w_result;
        end
    end

endmodule

FILE: design/multi_mode_crc_engine_top.sv
// Configurable CRC engine over a byte stream: one byte per beat on the push side, one
// finished check value per beat on the pop side, one byte per clock sustained while the pop
// side keeps up. A beat waits in the byte queue until the back end takes it and folds it
// into the CRC by an eight-step XOR network; a last beat's result goes into the result
// queue, read in order on o_check_value. The back end stalls only while both result slots
// wait to be popped. Modes (register 0): crc4, crc7, crc8, crc8 reflected, crc16
// MSB-first, crc16 LSB-first; codes 6 and 7 behave as crc8. Poly (register 1) and init
// (register 2) use their low 4, 7, 8 or 16 bits per mode; the reflected 8-bit mode
// bit-reverses both. A beat with first set reloads from init; a beat with last set
// yields a result, zero-extended to 16 bits. Write config only with the engine idle.
module multi_mode_crc_engine_top #(
    parameter int QUEUE_DEPTH  = 4,  // classified bytes between front and back end
    parameter int RESULT_DEPTH = 2   // finished results awaiting pop
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write channel
    input  logic                             i_cfg_valid,
    input  logic [mmcrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mmcrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                             o_cfg_ready,
    // byte side
    input  logic                             push,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_first_byte,
    input  logic                             i_last_byte,
    output logic                             full,
    // result side
    output logic                             empty,
    input  logic                             pop,
    output logic [15:0]                      o_check_value
);

    mmcrc_pkg::t_item w_item;
    logic             w_item_valid;
    logic             w_item_take;

    // front end: config registers, mode decode, byte queue
    mmcrc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_full       (full),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_take  (w_item_take)
    );

    // back end: CRC register, bit steps, result queue
    mmcrc_back #(
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_item),
        .i_item_valid  (w_item_valid),
        .o_item_take   (w_item_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_check_value (o_check_value)
    );

endmodule

FILE: design/mmcrc_checker.sv
module mmcrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_check_value
);

    // reset empties both queues
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // the byte queue only fills on a push
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_check_value))
        else $error("waiting result changed or vanished");

endmodule

bind multi_mode_crc_engine_top mmcrc_checker u_checker (.*);

FILE: dv/tb_multi_mode_crc_engine_top.sv
`timescale 1ns / 100ps

// Testbench for the multi-mode CRC engine.
// Bytes go in through the push/full side, and check values come out through the
// empty/pop side.
// Each accepted beat is folded into a shadow CRC register.
// Each beat flagged last queues the check value it should produce, and the pop side
// compares results against that queue in order.
// Config is only rewritten once every queued result has been popped and the
// engine has had time to finish any bytes still in flight.
module tb_multi_mode_crc_engine_top;

    // mode codes without a name in the package; both behave as plain crc8
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    // cycles allowed after the last result for in-flight bytes to drain
    // (byte queue plus back-end CRC register, with margin)
    localparam int SETTLE_CYCLES   = 16;
    localparam int RANDOM_PHASES   = 12;
    localparam int BYTES_PER_PHASE = 152;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_valid;
    logic [mmcrc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mmcrc_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                             o_cfg_ready;
    logic                             push;
    logic [7:0]                       i_data_byte;
    logic                             i_first_byte;
    logic                             i_last_byte;
    logic                             full;
    logic                             empty;
    logic                             pop;
    logic [15:0]                      o_check_value;

    // every mode code the register can hold, spare ones included
    logic [2:0] mode_list [8] = '{mmcrc_pkg::MODE_CRC4, mmcrc_pkg::MODE_CRC7,
                                  mmcrc_pkg::MODE_CRC8, mmcrc_pkg::MODE_CRC8_REF,
                                  mmcrc_pkg::MODE_CRC16_MSB, mmcrc_pkg::MODE_CRC16_LSB,
                                  MODE_SPARE6, MODE_SPARE7};

    // shadow copy of the engine's config and CRC register
    logic [2:0]  mode_sh;
    logic [15:0] poly_sh;
    logic [15:0] init_sh;
    logic [15:0] crc_reg_sh;

    logic [15:0] crc_due [$];   // check values still owed by the engine, oldest first
    int          mismatch_count = 0;
    bit          push_steady = 1'b0;   // no gaps on the byte side
    bit          pop_steady  = 1'b0;   // no stalls on the result side

    multi_mode_crc_engine_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .push          (push),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .i_last_byte   (i_last_byte),
        .full          (full),
        .empty         (empty),
        .pop           (pop),
        .o_check_value (o_check_value)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] mirror_byte(input logic [7:0] x);
        logic [7:0] y;
        for (int i = 0; i < 8; i++) begin
            y[i] = x[7-i];
        end
        return y;
    endfunction

    // Fold one accepted beat into the shadow register. On a last beat, queue the
    // check value, trimmed to the mode's width.
    task automatic crc_fold_byte(input logic [7:0] d, input logic first, input logic last);
        mmcrc_pkg::t_mode m;
        logic [15:0]      gen;
        logic [15:0]      load;
        logic [15:0]      r;
        // spare codes fall back to crc8
        if (mode_sh > mmcrc_pkg::MODE_CRC16_LSB) m = mmcrc_pkg::MODE_CRC8;
        else m = mmcrc_pkg::t_mode'(mode_sh);

        // narrow modes run left-aligned in an 8-bit window
        case (m)
            mmcrc_pkg::MODE_CRC4: begin
                gen  = {8'h00, poly_sh[3:0], 4'h0};
                load = {8'h00, init_sh[3:0], 4'h0};
            end
            mmcrc_pkg::MODE_CRC7: begin
                gen  = {8'h00, poly_sh[6:0], 1'b0};
                load = {8'h00, init_sh[6:0], 1'b0};
            end
            mmcrc_pkg::MODE_CRC8: begin
                gen  = {8'h00, poly_sh[7:0]};
                load = {8'h00, init_sh[7:0]};
            end
            mmcrc_pkg::MODE_CRC8_REF: begin
                gen  = {8'h00, mirror_byte(poly_sh[7:0])};
                load = {8'h00, mirror_byte(init_sh[7:0])};
            end
            default: begin
                gen  = poly_sh;
                load = init_sh;
            end
        endcase

        if (first) crc_reg_sh = load;
        r = crc_reg_sh;

        case (m)
            mmcrc_pkg::MODE_CRC8_REF: begin
                r = {8'h00, r[7:0] ^ d};
                repeat (8) r = r[0] ? ((r >> 1) ^ gen) : (r >> 1);
            end
            mmcrc_pkg::MODE_CRC16_MSB: begin
                r = r ^ {d, 8'h00};
                repeat (8) r = r[15] ? ((r << 1) ^ gen) : (r << 1);
            end
            mmcrc_pkg::MODE_CRC16_LSB: begin
                r = r ^ {8'h00, d};
                repeat (8) r = r[0] ? ((r >> 1) ^ gen) : (r >> 1);
            end
            default: begin
                // 8-bit MSB-first window; upper byte dropped on a mode change
                r = {8'h00, r[7:0] ^ d};
                repeat (8) r = r[7] ? ({8'h00, r[6:0], 1'b0} ^ gen) : {8'h00, r[6:0], 1'b0};
            end
        endcase
        crc_reg_sh = r;

        if (last) begin
            case (m) inside
                mmcrc_pkg::MODE_CRC4: crc_due.push_back({12'h000, r[7:4]});
                mmcrc_pkg::MODE_CRC7: crc_due.push_back({9'h000, r[7:1]});
                mmcrc_pkg::MODE_CRC8,
                mmcrc_pkg::MODE_CRC8_REF: crc_due.push_back({8'h00, r[7:0]});
                default:                  crc_due.push_back(r);
            endcase
        end
    endtask

    // Offer one beat and hold it until accepted. Any idle gap follows the beat, so
    // push is never lowered and raised in the same step. During the gap, the fields
    // carry junk that must be ignored.
    task automatic send_byte(input logic [7:0] d, input logic first, input logic last);
        int gap;
        @(negedge i_clk);
        push         <= 1'b1;
        i_data_byte  <= d;
        i_first_byte <= first;
        i_last_byte  <= last;
        do @(posedge i_clk); while (full);
        crc_fold_byte(d, first, last);
        gap = pick_gap(push_steady);
        if (gap > 0) begin
            @(negedge i_clk);
            push         <= 1'b0;
            i_data_byte  <= 8'($urandom);
            i_first_byte <= 1'($urandom);
            i_last_byte  <= 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stop pushing, wait until every owed result has been popped, then let
    // result-less bytes still in the pipe finish.
    task automatic settle_engine();
        @(negedge i_clk);
        push <= 1'b0;
        while (crc_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input mmcrc_pkg::t_cfg_reg idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mmcrc_pkg::CFG_MODE: mode_sh = value[2:0];
            mmcrc_pkg::CFG_POLY: poly_sh = value;
            mmcrc_pkg::CFG_INIT: init_sh = value;
            default:  ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [2:0] mode, input logic [15:0] poly,
                             input logic [15:0] init);
        write_reg(mmcrc_pkg::CFG_MODE, {13'h0000, mode});
        write_reg(mmcrc_pkg::CFG_POLY, poly);
        write_reg(mmcrc_pkg::CFG_INIT, init);
    endtask

    // After reset: crc8, poly 0x07, init 0. A message without a first flag
    // continues from the zero register. Then comes a one-byte message.
    task automatic test_reset_state();
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b1, 1'b1);
        settle_engine();
    endtask

    // Every mode code, spares included, with poly and init at their extremes.
    task automatic test_each_mode();
        logic [15:0] poly;
        logic [15:0] init;
        foreach (mode_list[k]) begin
            poly = mode_list[k][0] ? 16'hFFFF : 16'h0000;
            init = mode_list[k][1] ? 16'hFFFF : 16'h0000;
            write_all(mode_list[k], poly, init);
            send_byte(8'hFF, 1'b1, 1'b0);
            send_byte(8'h00, 1'b0, 1'b1);
            settle_engine();
        end
    endtask

    // Mode switched mid-message, in both directions: the 16-bit register is cut to
    // its low byte on the way down and taken as it is on the way up.
    task automatic test_mode_switch();
        write_all(mmcrc_pkg::MODE_CRC16_MSB, 16'h1021, 16'hFFFF);
        send_byte(8'h5A, 1'b1, 1'b0);
        settle_engine();
        write_reg(mmcrc_pkg::CFG_MODE, {13'h0000, mmcrc_pkg::MODE_CRC8});
        send_byte(8'h3C, 1'b0, 1'b1);
        send_byte(8'hC3, 1'b1, 1'b0);
        settle_engine();
        write_reg(mmcrc_pkg::CFG_MODE, {13'h0000, mmcrc_pkg::MODE_CRC16_LSB});
        send_byte(8'h81, 1'b0, 1'b1);
        settle_engine();
    endtask

    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Random phases, each with a fresh config. Most traffic is well-formed messages
    // with random bytes. The rest is continuations without a first flag and beats
    // with random flags.
    task automatic test_random_traffic();
        logic [2:0]  mode;
        logic [15:0] mode_word;
        int          sent;
        int          len;
        int          kind;
        int          r;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle_engine();
            push_steady = (ph % 4 == 3);
            pop_steady  = (ph % 4 == 1);
            mode = mode_list[$urandom_range(0, 7)];
            // upper bits of the mode word are don't-care; exercise them now and then
            mode_word = ($urandom_range(0, 3) == 0) ? {13'($urandom), mode}
                                                    : {13'h0000, mode};
            write_reg(mmcrc_pkg::CFG_MODE, mode_word);
            write_reg(mmcrc_pkg::CFG_POLY, pick_word());
            write_reg(mmcrc_pkg::CFG_INIT, pick_word());
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 85) len = $urandom_range(1, 6);
                else if (r < 95) len = $urandom_range(7, 16);
                else len = $urandom_range(17, 40);
                kind = $urandom_range(0, 99);
                for (int b = 0; b < len; b++) begin
                    if (kind < 80)
                        send_byte(8'($urandom), b == 0, b == len - 1);
                    else if (kind < 90)
                        send_byte(8'($urandom), 1'b0, b == len - 1);
                    else
                        send_byte(8'($urandom), 1'($urandom), 1'($urandom));
                end
                sent += len;
            end
        end
        push_steady = 1'b0;
        pop_steady  = 1'b0;
        settle_engine();
    endtask

    // result side: pop held high except for random stalls
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                stall_left = pick_gap(pop_steady);
            end
        end
    end

    // each popped beat against the oldest owed check value
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && pop && !empty) begin
            if (crc_due.size() == 0) begin
                $error("check_value: unexpected result, expected none, actual 0x%04h",
                       o_check_value);
                mismatch_count++;
            end else begin
                want = crc_due.pop_front();
                if (o_check_value !== want) begin
                    $error("check_value: expected 0x%04h, actual 0x%04h", want, o_check_value);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = mmcrc_pkg::CFG_MODE;
        i_cfg_data   = '0;
        push         = 1'b0;
        i_data_byte  = 8'h00;
        i_first_byte = 1'b0;
        i_last_byte  = 1'b0;
        pop          = 1'b0;
        mode_sh      = mmcrc_pkg::MODE_RESET;
        poly_sh      = mmcrc_pkg::POLY_RESET;
        init_sh      = mmcrc_pkg::INIT_RESET;
        crc_reg_sh   = 16'h0000;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_each_mode();
        test_mode_switch();
        test_random_traffic();

        if (mismatch_count == 0 && crc_due.size() == 0) begin
            $display("tb_multi_mode_crc_engine_top: PASS");
        end else begin
            $display("tb_multi_mode_crc_engine_top: FAIL");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("tb_multi_mode_crc_engine_top: FAIL");
        $finish;
    end

endmodule
